/* rtl/sws_pkg.sv */
// sws_pkg: shared types and codes for the stack with search block.
// Used by sws_mem, sws_seq and stack_with_search_top; depends on nothing.
package sws_pkg;

   // operation codes on req_func
   localparam logic [1:0] FN_PUSH   = 2'd0;
   localparam logic [1:0] FN_POP    = 2'd1;
   localparam logic [1:0] FN_SEARCH = 2'd2;
   localparam logic [1:0] FN_CLEAR  = 2'd3;

   // status codes on rsp_status
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_UNDERFLOW = 3'd1;
   localparam logic [2:0] STS_OVERFLOW  = 3'd2;
   localparam logic [2:0] STS_FOUND     = 3'd3;
   localparam logic [2:0] STS_NOT_FOUND = 3'd4;

   localparam int WORD_W  = 32;
   localparam int FIELD_W = 6;   // width of fill_count and match_position
   localparam int MAX_RESULTS = 32;
   localparam int NMATCH_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_KEY
   } word_src_type;

   typedef struct packed {
      logic                valid;
      logic [2:0]          status;
      logic [FIELD_W-1:0]  match_position;
      word_src_type        src;
      logic                last;
   } rsp_ctl_type;

endpackage

/* rtl/sws_mem.sv */
// sws_mem: entry store of the stack, one write port and one registered read port.
// Uses sws_pkg for the word width.
module sws_mem #(
   parameter int STACK_DEPTH = 32,
   parameter int AW = $clog2(STACK_DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [sws_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [sws_pkg::WORD_W-1:0] rd_data
);

   logic [sws_pkg::WORD_W-1:0] mem_ff [STACK_DEPTH];
   logic [sws_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sws_seq.sv */
// sws_seq: fill counter, operation sequencer and the shared compare used by search.
// Uses sws_pkg for codes, state and response types; drives sws_mem ports.
module sws_seq #(
   parameter int STACK_DEPTH = 32,
   parameter int AW = $clog2(STACK_DEPTH),
   parameter int CW = $clog2(STACK_DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [1:0]                 func,
   input  logic [sws_pkg::WORD_W-1:0] data_word,
   output logic                       busy,
   output logic                       wr_en,
   output logic [AW-1:0]              wr_addr,
   output logic                       rd_en,
   output logic [AW-1:0]              rd_addr,
   input  logic [sws_pkg::WORD_W-1:0] rd_data,
   output sws_pkg::rsp_ctl_type       rsp_ctl,
   output logic [sws_pkg::WORD_W-1:0] rsp_word,
   output logic [CW-1:0]              count
);

   sws_pkg::state_type             state_ff, state_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [sws_pkg::WORD_W-1:0]     key_ff, key_in;
   logic [AW-1:0]                  addr_ff, addr_in;
   logic [CW-1:0]                  pos_ff, pos_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [CW-1:0]                  pend_pos_ff, pend_pos_in;
   logic [sws_pkg::NMATCH_W-1:0]   nmatch_ff, nmatch_in;
   sws_pkg::rsp_ctl_type           rsp_ff, rsp_in;
   logic                           match;
   logic                           more;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sws_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_ff        <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      addr_ff     <= addr_in;
      pos_ff      <= pos_in;
      pend_pos_ff <= pend_pos_in;
      nmatch_ff   <= nmatch_in;
   end

   // shared comparator: current entry against the search key
   assign match = (rd_data == key_ff);
   assign more  = (addr_ff != '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      addr_in       = addr_ff;
      pos_in        = pos_ff;
      pend_valid_in = pend_valid_ff;
      pend_pos_in   = pend_pos_ff;
      nmatch_in     = nmatch_ff;
      rsp_in        = '0;
      rsp_in.src    = sws_pkg::SRC_ZERO;
      wr_en         = 1'b0;
      wr_addr       = AW'(count_ff);
      rd_en         = 1'b0;
      rd_addr       = addr_ff - AW'(1);

      case (state_ff)
         sws_pkg::ST_IDLE: begin
            if (start) begin
               rsp_in.valid  = 1'b1;
               rsp_in.last   = 1'b1;
               rsp_in.status = sws_pkg::STS_OK;
               key_in        = data_word;
               case (func)
                  sws_pkg::FN_PUSH: begin
                     if (count_ff == CW'(STACK_DEPTH)) begin
                        rsp_in.status = sws_pkg::STS_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  sws_pkg::FN_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = sws_pkg::STS_UNDERFLOW;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_ff - CW'(1));
                        count_in   = count_ff - CW'(1);
                        rsp_in.src = sws_pkg::SRC_MEM;
                     end
                  end
                  sws_pkg::FN_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_in.status = sws_pkg::STS_NOT_FOUND;
                     end else begin
                        // fetch the top entry, then walk down one entry a cycle
                        rsp_in.valid  = 1'b0;
                        rd_en         = 1'b1;
                        rd_addr       = AW'(count_ff - CW'(1));
                        addr_in       = AW'(count_ff - CW'(1));
                        pos_in        = CW'(1);
                        pend_valid_in = 1'b0;
                        nmatch_in     = '0;
                        state_in      = sws_pkg::ST_WALK;
                     end
                  end
                  sws_pkg::FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     rsp_in.valid = 1'b0;
                  end
               endcase
            end
         end

         sws_pkg::ST_WALK: begin
            if (more) begin
               rd_en   = 1'b1;
               addr_in = addr_ff - AW'(1);
               pos_in  = pos_ff + CW'(1);
            end
            if (match) begin
               // hold the newest match back until we know whether it is the last
               nmatch_in     = nmatch_ff + sws_pkg::NMATCH_W'(1);
               pend_valid_in = 1'b1;
               pend_pos_in   = pos_ff;
               if (pend_valid_ff) begin
                  rsp_in.valid          = 1'b1;
                  rsp_in.status         = sws_pkg::STS_FOUND;
                  rsp_in.match_position = sws_pkg::FIELD_W'(pend_pos_ff);
                  rsp_in.src            = sws_pkg::SRC_KEY;
               end
            end
            if (!more || nmatch_in == sws_pkg::NMATCH_W'(sws_pkg::MAX_RESULTS)) begin
               state_in = sws_pkg::ST_FLUSH;
            end
         end

         sws_pkg::ST_FLUSH: begin
            rsp_in.valid = 1'b1;
            rsp_in.last  = 1'b1;
            if (pend_valid_ff) begin
               rsp_in.status         = sws_pkg::STS_FOUND;
               rsp_in.match_position = sws_pkg::FIELD_W'(pend_pos_ff);
               rsp_in.src            = sws_pkg::SRC_KEY;
            end else begin
               rsp_in.status = sws_pkg::STS_NOT_FOUND;
            end
            pend_valid_in = 1'b0;
            state_in      = sws_pkg::ST_IDLE;
         end

         default: begin
            state_in = sws_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      case (rsp_ff.src)
         sws_pkg::SRC_MEM: rsp_word = rd_data;
         sws_pkg::SRC_KEY: rsp_word = key_ff;
         default:          rsp_word = '0;
      endcase
   end

   assign busy    = (state_ff != sws_pkg::ST_IDLE);
   assign rsp_ctl = rsp_ff;
   assign count   = count_ff;

endmodule

/* rtl/stack_with_search_top.sv */
// stack_with_search_top: bounded LIFO of 32-bit words with push, pop, search and clear.
// Push, pop, clear, search of an empty stack: busy stays low, one beat per cycle, result
//   beat on rsp_* in the cycle after start is taken.
// Search: busy stays high through the walk (one compare per entry) and one flush state;
//   a found beat waits for the next match or the flush; the last shows as busy falls.
// Reset clears fill count and sequencer, not the entries; the receiver cannot stall.
module stack_with_search_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_data_word,
   // result channel
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_match_position,
   output logic signed [31:0] rsp_result_word,
   output logic               rsp_is_empty,
   output logic [5:0]         rsp_fill_count,
   output logic               rsp_last
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [sws_pkg::WORD_W-1:0]  rd_data;
   logic [sws_pkg::WORD_W-1:0]  rsp_word;
   logic [CW-1:0]               count;
   sws_pkg::rsp_ctl_type        rsp_ctl;

   // Sequencer: owns the fill count, decodes each beat and walks the
   // entries from the top during a search, one compare per cycle.
   sws_seq #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .func      (req_func),
      .data_word ($unsigned(req_data_word)),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_ctl   (rsp_ctl),
      .rsp_word  (rsp_word),
      .count     (count)
   );

   // Entry store: pushes write at the fill level, pops and the search walk
   // read through the one registered port.
   sws_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ($unsigned(req_data_word)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The fill count cannot change while a beat is shown: it moves only at
   // an accepted start, which lands on the same edge that raises the beat.
   assign rsp_valid          = rsp_ctl.valid;
   assign rsp_status         = rsp_ctl.status;
   assign rsp_match_position = rsp_ctl.match_position;
   assign rsp_last           = rsp_ctl.last;
   assign rsp_result_word    = $signed(rsp_word);
   assign rsp_is_empty       = (count == '0);
   assign rsp_fill_count     = sws_pkg::FIELD_W'(count);

endmodule
